>>> design/cct_pkg.sv
// Shared constants, types and codes of the collision contact tracker.
`timescale 1ns / 1ps

package cct_pkg;

  // Collider identifier width; the contact table holds one bit per ordered pair
  localparam int unsigned IdBits     = 6;
  localparam int unsigned AddrBits   = 2 * IdBits;
  localparam int unsigned TableDepth = 1 << AddrBits;

  // Field widths of one pair word
  localparam int unsigned PosBits  = 16;
  localparam int unsigned SizeBits = 12;

  // Arithmetic widths: position difference, doubled centre difference, squares
  localparam int unsigned DiffBits = PosBits + 1;
  localparam int unsigned CdBits   = PosBits + 3;
  localparam int unsigned SqBits   = 2 * CdBits - 2;
  localparam int unsigned SSqBits  = 2 * (SizeBits + 1);

  typedef enum logic {
    KindRect,
    KindCircle
  } kind_e;

  typedef enum logic [1:0] {
    EvNone,
    EvEnter,
    EvStay,
    EvExit
  } event_e;

  typedef enum logic {
    StClear,
    StRun
  } state_e;

  typedef struct packed {
    logic [IdBits-1:0]          left_id;
    logic [IdBits-1:0]          right_id;
    logic signed [PosBits-1:0]  left_x;
    logic signed [PosBits-1:0]  left_y;
    logic [SizeBits-1:0]        left_w;
    logic [SizeBits-1:0]        left_h;
    kind_e                      left_kind;
    logic signed [PosBits-1:0]  right_x;
    logic signed [PosBits-1:0]  right_y;
    logic [SizeBits-1:0]        right_w;
    logic [SizeBits-1:0]        right_h;
    kind_e                      right_kind;
  } in_word_t;

  typedef struct packed {
    event_e contact_event;
    logic   overlapping;
  } out_word_t;

  // Partial overlap results handed from the arithmetic stage to the decision stage
  typedef struct packed {
    logic               both_rect;
    logic               both_circle;
    logic               rect_hit;
    logic [SqBits-1:0]  dx_sq;
    logic [SqBits-1:0]  dy_sq;
    logic [SSqBits-1:0] size_sq;
  } geom_t;

endpackage

>>> design/cct_if.sv
// Valid/ready channel interfaces for pair words and contact result words.
`timescale 1ns / 1ps

interface cct_in_if;
  logic              valid;
  logic              ready;
  cct_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cct_out_if;
  logic               valid;
  logic               ready;
  cct_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/cct_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module cct_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write, and read the old contents on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/cct_overlap.sv
// Overlap arithmetic stage: differences, strict rectangle test and registered squares.
`timescale 1ns / 1ps

module cct_overlap (
  input  logic              clk_i,
  input  logic              en_i,
  input  cct_pkg::in_word_t word_i,
  output cct_pkg::geom_t    geom_o
);

  logic signed [cct_pkg::DiffBits-1:0]   dx;
  logic signed [cct_pkg::DiffBits-1:0]   dy;
  logic [cct_pkg::DiffBits-1:0]          adx;
  logic [cct_pkg::DiffBits-1:0]          ady;
  logic [cct_pkg::SizeBits:0]            wsum;
  logic [cct_pkg::SizeBits:0]            hsum;
  logic signed [cct_pkg::SizeBits:0]     wdiff;
  logic signed [cct_pkg::SizeBits:0]     hdiff;
  logic signed [cct_pkg::CdBits-1:0]     cdx;
  logic signed [cct_pkg::CdBits-1:0]     cdy;
  logic signed [2*cct_pkg::CdBits-1:0]   sqx;
  logic signed [2*cct_pkg::CdBits-1:0]   sqy;
  logic [cct_pkg::SSqBits-1:0]           ssq;
  cct_pkg::geom_t                        geom_d;
  cct_pkg::geom_t                        geom_q;

  // Centre distances and summed sizes
  always_comb begin
    dx    = cct_pkg::DiffBits'(word_i.left_x) - cct_pkg::DiffBits'(word_i.right_x);
    dy    = cct_pkg::DiffBits'(word_i.left_y) - cct_pkg::DiffBits'(word_i.right_y);
    adx   = dx[cct_pkg::DiffBits-1] ? cct_pkg::DiffBits'(-dx) : cct_pkg::DiffBits'(dx);
    ady   = dy[cct_pkg::DiffBits-1] ? cct_pkg::DiffBits'(-dy) : cct_pkg::DiffBits'(dy);
    wsum  = {1'b0, word_i.left_w} + {1'b0, word_i.right_w};
    hsum  = {1'b0, word_i.left_h} + {1'b0, word_i.right_h};
    wdiff = $signed({1'b0, word_i.left_w}) - $signed({1'b0, word_i.right_w});
    hdiff = $signed({1'b0, word_i.left_h}) - $signed({1'b0, word_i.right_h});
  end

  // Doubled centre offset of two circles given by their corners, then squares
  always_comb begin
    cdx = (cct_pkg::CdBits'(dx) <<< 1) + cct_pkg::CdBits'(wdiff);
    cdy = (cct_pkg::CdBits'(dy) <<< 1) + cct_pkg::CdBits'(hdiff);
    sqx = cdx * cdx;
    sqy = cdy * cdy;
    ssq = wsum * wsum;
  end

  // Strict box test on doubled distances, shape pairing
  always_comb begin
    geom_d.both_rect   = (word_i.left_kind == cct_pkg::KindRect) &&
                         (word_i.right_kind == cct_pkg::KindRect);
    geom_d.both_circle = (word_i.left_kind == cct_pkg::KindCircle) &&
                         (word_i.right_kind == cct_pkg::KindCircle);
    geom_d.rect_hit    = ({adx, 1'b0} < (cct_pkg::DiffBits + 1)'(wsum)) &&
                         ({ady, 1'b0} < (cct_pkg::DiffBits + 1)'(hsum));
    geom_d.dx_sq       = sqx[cct_pkg::SqBits-1:0];
    geom_d.dy_sq       = sqy[cct_pkg::SqBits-1:0];
    geom_d.size_sq     = ssq;
  end

  // Hold the results for the decision stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geom_q <= geom_d;
    end
  end

  assign geom_o = geom_q;

endmodule

>>> design/collision_contact_tracker.sv
// Collision contact tracker: pair overlap test with a per-pair contact bit table.
// Pipeline: an accepted pair word moves through the first-stage, arithmetic-stage
// and result registers. Throughput: one pair word per cycle while out_o.ready does
// not stall; the contact table is read at acceptance and written back from the
// decision stage, with forwarding between words that share a pair.
// Reset: a clearing pass writes all 4096 table entries, one a cycle, while in_i.ready is low.
`timescale 1ns / 1ps

module collision_contact_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  cct_in_if.sink     in_i,
  cct_out_if.source  out_o
);

  cct_pkg::state_e                state_q, state_d;
  logic [cct_pkg::AddrBits-1:0]   clr_cnt_q, clr_cnt_d;
  logic                           clearing;

  logic                           s1_valid_q, s1_valid_d;
  cct_pkg::in_word_t              s1_word_q;
  logic [cct_pkg::AddrBits-1:0]   s1_addr_q;
  logic                           s1_fwd_q, s1_fwd_d;
  logic                           s1_fwd_bit_q, s1_fwd_bit_d;

  logic                           s2_valid_q, s2_valid_d;
  logic [cct_pkg::AddrBits-1:0]   s2_addr_q;
  logic                           s2_was_q;
  cct_pkg::geom_t                 geom;

  logic                           out_valid_q, out_valid_d;
  cct_pkg::out_word_t             out_word_q;

  logic [cct_pkg::AddrBits-1:0]   in_addr;
  logic                           accept;
  logic                           out_adv, s2_adv, s2_free, s1_adv, s1_free;
  logic                           circ_hit, hit, was_now, wr_run;
  cct_pkg::event_e                ev;

  logic                           ram_we;
  logic [cct_pkg::AddrBits-1:0]   ram_waddr;
  logic                           ram_wdata;
  logic                           ram_rdata;

  // Clearing sequencer: next state
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      cct_pkg::StClear: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = cct_pkg::StRun;
        end
      end
      cct_pkg::StRun: begin
        state_d = cct_pkg::StRun;
      end
      default: begin
        state_d = cct_pkg::StClear;
      end
    endcase
  end

  // Clearing sequencer: outputs
  always_comb begin
    case (state_q)
      cct_pkg::StClear: clearing = 1'b1;
      cct_pkg::StRun:   clearing = 1'b0;
      default:          clearing = 1'b1;
    endcase
  end

  // Pipeline flow control
  always_comb begin
    out_adv = !out_valid_q || out_o.ready;
    s2_adv  = s2_valid_q && out_adv;
    s2_free = !s2_valid_q || s2_adv;
    s1_adv  = s1_valid_q && s2_free;
    s1_free = !s1_valid_q || s1_adv;
    accept  = in_i.valid && in_i.ready;
    in_addr = {in_i.data.left_id, in_i.data.right_id};
  end

  assign in_i.ready = s1_free && !clearing;

  // Arithmetic stage between the first and the decision stage
  cct_overlap u_overlap (
    .clk_i  (clk_i),
    .en_i   (s1_adv),
    .word_i (s1_word_q),
    .geom_o (geom)
  );

  // Decide overlap and event for the word in the decision stage
  always_comb begin
    circ_hit = ((cct_pkg::SqBits + 1)'(geom.dx_sq) + (cct_pkg::SqBits + 1)'(geom.dy_sq))
               <= (cct_pkg::SqBits + 1)'(geom.size_sq);
    hit      = (geom.both_rect && geom.rect_hit) || (geom.both_circle && circ_hit);
    if (hit) begin
      ev = s2_was_q ? cct_pkg::EvStay : cct_pkg::EvEnter;
    end else begin
      ev = s2_was_q ? cct_pkg::EvExit : cct_pkg::EvNone;
    end
    wr_run = s2_adv;
  end

  // Contact bit of the first-stage word, forwarding writes since its read
  always_comb begin
    if (wr_run && (s2_addr_q == s1_addr_q)) begin
      was_now = hit;
    end else if (s1_fwd_q) begin
      was_now = s1_fwd_bit_q;
    end else begin
      was_now = ram_rdata;
    end
  end

  // Next values of the control registers
  always_comb begin
    s1_fwd_d     = s1_fwd_q;
    s1_fwd_bit_d = s1_fwd_bit_q;
    if (accept) begin
      s1_valid_d   = 1'b1;
      s1_fwd_d     = wr_run && (s2_addr_q == in_addr);
      s1_fwd_bit_d = hit;
    end else begin
      s1_valid_d = s1_adv ? 1'b0 : s1_valid_q;
      if (wr_run && (s2_addr_q == s1_addr_q)) begin
        s1_fwd_d     = 1'b1;
        s1_fwd_bit_d = hit;
      end
    end
    if (s1_adv) begin
      s2_valid_d = 1'b1;
    end else begin
      s2_valid_d = s2_adv ? 1'b0 : s2_valid_q;
    end
    if (s2_adv) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_o.ready ? 1'b0 : out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cct_pkg::StClear;
      clr_cnt_q    <= '0;
      s1_valid_q   <= 1'b0;
      s1_fwd_q     <= 1'b0;
      s1_fwd_bit_q <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      s1_valid_q   <= s1_valid_d;
      s1_fwd_q     <= s1_fwd_d;
      s1_fwd_bit_q <= s1_fwd_bit_d;
      s2_valid_q   <= s2_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: advance with their stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q <= in_i.data;
      s1_addr_q <= in_addr;
    end
    if (s1_adv) begin
      s2_addr_q <= s1_addr_q;
      s2_was_q  <= was_now;
    end
    if (s2_adv) begin
      out_word_q.contact_event <= ev;
      out_word_q.overlapping   <= hit;
    end
  end

  // Contact table: clearing pass after reset, then write-back from the decision stage
  always_comb begin
    ram_we    = clearing || wr_run;
    ram_waddr = clearing ? clr_cnt_q : s2_addr_q;
    ram_wdata = clearing ? 1'b0 : hit;
  end

  cct_ram #(
    .Width (1),
    .Depth (cct_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

endmodule

>>> design/cct_checker.sv
// Port-level checks of the collision contact tracker and their binding.
`timescale 1ns / 1ps

module cct_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input cct_pkg::out_word_t out_data_i
);

  // A stalled result word holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  // The event agrees with the overlap flag
  a_event_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.overlapping ==
      ((out_data_i.contact_event == cct_pkg::EvEnter) ||
       (out_data_i.contact_event == cct_pkg::EvStay))))
    else $error("contact event disagrees with overlap flag");

  // No word is taken at the release of reset, when the table clearing starts
  a_clear_ready: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("input ready during table clearing");

  // No result appears without a pair word having been taken for it
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 3))
    else $error("result word without an accepted pair word");

endmodule

bind collision_contact_tracker cct_checker u_cct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
